// File: sv/code_breakpoint_match_unit_defines.svh
// assertion macros for the code breakpoint match unit
// used by the top level and the breakpoint table; needs nothing else
`ifndef CODE_BREAKPOINT_MATCH_UNIT_DEFINES_SVH
`define CODE_BREAKPOINT_MATCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CBM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbm assertion failed");
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbm assertion failed");
`else
`define CBM_ASSERT_SAME(label, clk, rst, ante, cons)
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/cbm_pkg.sv
// shared types and constants of the code breakpoint match unit
// no dependencies
package cbm_pkg;

  localparam int unsigned CBM_MAX_BREAKPOINTS = 16;

  typedef enum logic [2:0] {
    REQ_CHECK      = 3'd0,
    REQ_ADD        = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_EXISTS     = 3'd3,
    REQ_RESUME     = 3'd4,
    REQ_REMOVE_ALL = 3'd5
  } cbm_req_t;

  // command from the controller to the table
  typedef struct packed {
    logic add;
    logic remove;
    logic clear_all;
  } cbm_tbl_cmd_t;

  // lookup status from the table
  typedef struct packed {
    logic hit;
    logic full;
  } cbm_tbl_stat_t;

  typedef struct packed {
    logic        ok;
    logic        table_full;
    logic        pause_game_cmd;
    logic        unpause_game_cmd;
    logic        pause_thread_cmd;
    logic        run_thread_cmd;
    logic        active_valid;
    logic [31:0] active_script;
    logic [31:0] active_pc;
  } cbm_result_t;

endpackage

// File: sv/cbm_if.sv
// valid/ready channels of the code breakpoint match unit
// request, response and configuration write; no dependencies
interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] script_id;
  logic [31:0] prog_counter;
  logic        current_thread_present;
  logic        active_thread_alive;

  modport source (output valid, req_type, script_id, prog_counter,
                  current_thread_present, active_thread_alive, input ready);
  modport sink (input valid, req_type, script_id, prog_counter,
                current_thread_present, active_thread_alive, output ready);
endinterface

interface cbm_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        table_full;
  logic        pause_game_cmd;
  logic        unpause_game_cmd;
  logic        pause_thread_cmd;
  logic        run_thread_cmd;
  logic        active_valid;
  logic [31:0] active_script;
  logic [31:0] active_pc;

  modport source (output valid, ok, table_full, pause_game_cmd, unpause_game_cmd,
                  pause_thread_cmd, run_thread_cmd, active_valid, active_script,
                  active_pc, input ready);
  modport sink (input valid, ok, table_full, pause_game_cmd, unpause_game_cmd,
                pause_thread_cmd, run_thread_cmd, active_valid, active_script,
                active_pc, output ready);
endinterface

interface cbm_cfg_if;
  logic valid;
  logic ready;
  logic pause_whole_game;

  modport source (output valid, pause_whole_game, input ready);
  modport sink (input valid, pause_whole_game, output ready);
endinterface

// File: sv/code_breakpoint_match_unit.sv
// code breakpoint match unit, top level: request register, result register
// depends on cbm_pkg, cbm_if, cbm_table, cbm_ctrl and the macro header
//
// Breakpoint comparator for a script interpreter. Takes one request per clock
// while rsp.ready does not hold it off (check executing pc, add, remove, exists,
// resume, remove all) and returns one response per request, in order. A request
// is captured in the request register on transfer and its response in the
// response register; back-pressure on rsp holds the response register and,
// while a request waits in the request register, drops req.ready. In a single
// compare pass every table entry is compared against the (script id, pc) pair in
// parallel, and the active breakpoint and flags are updated at the same edge that
// loads the response. pause_whole_game is written through the cfg channel,
// which is always ready; write it only while no request is in flight.
`include "code_breakpoint_match_unit_defines.svh"

module code_breakpoint_match_unit #(
  parameter int unsigned MAX_BREAKPOINTS = cbm_pkg::CBM_MAX_BREAKPOINTS
) (
  input  logic      clk,
  input  logic      rst,
  cbm_cfg_if.sink   cfg,
  cbm_req_if.sink   req,
  cbm_rsp_if.source rsp
);
  import cbm_pkg::*;

  // configuration register
  logic pause_whole_game;

  // request register
  logic        in_valid;
  logic [2:0]  in_req_type;
  logic [31:0] in_script_id;
  logic [31:0] in_prog_counter;
  logic        in_present;
  logic        in_alive;

  // response register
  logic        rsp_valid;
  cbm_result_t rsp_q;

  logic          advance;
  logic          fire;
  cbm_tbl_cmd_t  tbl_cmd;
  cbm_tbl_stat_t tbl_stat;
  cbm_result_t   result;

  // response slot free or being taken this cycle
  assign advance   = !rsp_valid || rsp.ready;
  assign fire      = in_valid && advance;
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_whole_game <= 1'b0;
    end else if (cfg.valid) begin
      pause_whole_game <= cfg.pause_whole_game;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // payload capture on request transfer
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type     <= req.req_type;
      in_script_id    <= req.script_id;
      in_prog_counter <= req.prog_counter;
      in_present      <= req.current_thread_present;
      in_alive        <= req.active_thread_alive;
    end
  end

  cbm_table #(
    .MAX_BREAKPOINTS (MAX_BREAKPOINTS)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .script_id    (in_script_id),
    .prog_counter (in_prog_counter),
    .cmd          (tbl_cmd),
    .stat         (tbl_stat)
  );

  cbm_ctrl u_ctrl (
    .clk                    (clk),
    .rst                    (rst),
    .fire                   (fire),
    .pause_whole_game       (pause_whole_game),
    .req_type               (in_req_type),
    .script_id              (in_script_id),
    .prog_counter           (in_prog_counter),
    .current_thread_present (in_present),
    .active_thread_alive    (in_alive),
    .stat                   (tbl_stat),
    .cmd                    (tbl_cmd),
    .result                 (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_q <= result;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.ok               = rsp_q.ok;
  assign rsp.table_full       = rsp_q.table_full;
  assign rsp.pause_game_cmd   = rsp_q.pause_game_cmd;
  assign rsp.unpause_game_cmd = rsp_q.unpause_game_cmd;
  assign rsp.pause_thread_cmd = rsp_q.pause_thread_cmd;
  assign rsp.run_thread_cmd   = rsp_q.run_thread_cmd;
  assign rsp.active_valid     = rsp_q.active_valid;
  assign rsp.active_script    = rsp_q.active_script;
  assign rsp.active_pc        = rsp_q.active_pc;

  // a refused add never reports success
  `CBM_ASSERT_SAME(a_full_not_ok, clk, rst, rsp_valid && rsp_q.table_full, !rsp_q.ok)
  // at most one pause or resume command per response
  `CBM_ASSERT_SAME(a_one_cmd, clk, rst, rsp_valid,
    $onehot0({rsp_q.pause_game_cmd, rsp_q.unpause_game_cmd,
              rsp_q.pause_thread_cmd, rsp_q.run_thread_cmd}))
  // no active breakpoint means zero fields
  `CBM_ASSERT_SAME(a_idle_zero, clk, rst, rsp_valid && !rsp_q.active_valid,
    rsp_q.active_script == '0 && rsp_q.active_pc == '0)

endmodule

// File: sv/cbm_table.sv
// breakpoint table: valid bits, stored pairs and parallel compare
// depends on cbm_pkg and the assertion macro header
`include "code_breakpoint_match_unit_defines.svh"

module cbm_table #(
  parameter int unsigned MAX_BREAKPOINTS = cbm_pkg::CBM_MAX_BREAKPOINTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            script_id,
  input  logic [31:0]            prog_counter,
  input  cbm_pkg::cbm_tbl_cmd_t  cmd,
  output cbm_pkg::cbm_tbl_stat_t stat
);
  import cbm_pkg::*;

  logic [MAX_BREAKPOINTS-1:0] entry_valid;
  logic [31:0]                entry_script [MAX_BREAKPOINTS];
  logic [31:0]                entry_pc     [MAX_BREAKPOINTS];
  logic [MAX_BREAKPOINTS-1:0] match;
  logic [MAX_BREAKPOINTS-1:0] free_slot;

  always_comb begin
    for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
      match[i] = entry_valid[i] && (entry_script[i] == script_id) &&
                 (entry_pc[i] == prog_counter);
    end
  end

  // lowest clear bit of the valid vector
  assign free_slot = ~entry_valid & (entry_valid + MAX_BREAKPOINTS'(1));
  assign stat.hit  = |match;
  assign stat.full = &entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.clear_all) begin
      entry_valid <= '0;
    end else if (cmd.remove) begin
      entry_valid <= entry_valid & ~match;
    end else if (cmd.add) begin
      entry_valid <= entry_valid | free_slot;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
      if (cmd.add && free_slot[i]) begin
        entry_script[i] <= script_id;
        entry_pc[i]     <= prog_counter;
      end
    end
  end

  `CBM_ASSERT_SAME(a_match_unique, clk, rst, 1'b1, $onehot0(match))
  `CBM_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.clear_all, entry_valid == '0)
  // an add only ever lands on a new pair with room left
  `CBM_ASSERT_SAME(a_add_has_room, clk, rst, cmd.add, !stat.full && !stat.hit)

endmodule

// File: sv/cbm_ctrl.sv
// breakpoint controller: active breakpoint, skip-once and pause bookkeeping
// depends on cbm_pkg; drives the table and builds the result
module cbm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic                   pause_whole_game,
  input  logic [2:0]             req_type,
  input  logic [31:0]            script_id,
  input  logic [31:0]            prog_counter,
  input  logic                   current_thread_present,
  input  logic                   active_thread_alive,
  input  cbm_pkg::cbm_tbl_stat_t stat,
  output cbm_pkg::cbm_tbl_cmd_t  cmd,
  output cbm_pkg::cbm_result_t   result
);
  import cbm_pkg::*;

  logic        hold_valid, hold_valid_next;
  logic [31:0] hold_script, hold_script_next;
  logic [31:0] hold_pc, hold_pc_next;
  logic        skip_next_hit, skip_next_hit_next;
  logic        game_was_paused, game_was_paused_next;
  logic        can_resume;
  cbm_tbl_cmd_t cmd_raw;

  assign can_resume = hold_valid && active_thread_alive;

  always_comb begin
    hold_valid_next      = hold_valid;
    hold_script_next     = hold_script;
    hold_pc_next         = hold_pc;
    skip_next_hit_next   = skip_next_hit;
    game_was_paused_next = game_was_paused;
    cmd_raw              = '0;
    result               = '0;

    case (cbm_req_t'(req_type))
      REQ_CHECK: begin
        if (current_thread_present) begin
          // active thread gone: forget the breakpoint and the skip
          if (hold_valid && !active_thread_alive) begin
            skip_next_hit_next = 1'b0;
            hold_valid_next    = 1'b0;
            hold_script_next   = '0;
            hold_pc_next       = '0;
          end
          if (stat.hit) begin
            if (skip_next_hit_next) begin
              skip_next_hit_next = 1'b0;
            end else begin
              hold_valid_next  = 1'b1;
              hold_script_next = script_id;
              hold_pc_next     = prog_counter;
              result.ok        = 1'b1;
              if (pause_whole_game) begin
                result.pause_game_cmd = 1'b1;
                game_was_paused_next  = 1'b1;
              end else begin
                result.pause_thread_cmd = 1'b1;
              end
            end
          end
        end
      end
      REQ_ADD: begin
        if (!stat.hit) begin
          if (stat.full) begin
            result.table_full = 1'b1;
          end else begin
            cmd_raw.add = 1'b1;
            result.ok   = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (stat.hit) begin
          cmd_raw.remove = 1'b1;
          result.ok      = 1'b1;
          if (can_resume && hold_script == script_id && hold_pc == prog_counter) begin
            result.unpause_game_cmd = game_was_paused;
            result.run_thread_cmd   = !game_was_paused;
            game_was_paused_next    = 1'b0;
            skip_next_hit_next      = 1'b1;
            hold_valid_next         = 1'b0;
            hold_script_next        = '0;
            hold_pc_next            = '0;
          end
        end
      end
      REQ_EXISTS: begin
        result.ok = stat.hit;
      end
      REQ_RESUME, REQ_REMOVE_ALL: begin
        cmd_raw.clear_all = (cbm_req_t'(req_type) == REQ_REMOVE_ALL);
        if (can_resume) begin
          result.ok               = 1'b1;
          result.unpause_game_cmd = game_was_paused;
          result.run_thread_cmd   = !game_was_paused;
          game_was_paused_next    = 1'b0;
          skip_next_hit_next      = 1'b1;
          hold_valid_next         = 1'b0;
          hold_script_next        = '0;
          hold_pc_next            = '0;
        end
      end
      default: begin
      end
    endcase

    result.active_valid  = hold_valid_next;
    result.active_script = hold_script_next;
    result.active_pc     = hold_pc_next;
  end

  assign cmd = fire ? cmd_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid      <= 1'b0;
      hold_script     <= '0;
      hold_pc         <= '0;
      skip_next_hit   <= 1'b0;
      game_was_paused <= 1'b0;
    end else if (fire) begin
      hold_valid      <= hold_valid_next;
      hold_script     <= hold_script_next;
      hold_pc         <= hold_pc_next;
      skip_next_hit   <= skip_next_hit_next;
      game_was_paused <= game_was_paused_next;
    end
  end

endmodule
